FILE: design/pfsa_pkg.sv
package pfsa_pkg;

   // field widths
   localparam int ADDR_W   = 48;
   localparam int LEN_W    = 49;
   localparam int END_W    = 50;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int FREE_W   = 11;
   localparam int USED_W   = 37;

   // default sizes
   localparam int STACK_DEPTH_DEF = 1024;
   localparam int MAX_REGIONS_DEF = 16;
   localparam int PAGE_BYTES_DEF  = 4096;

   // opcodes
   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
   localparam logic [OP_W-1:0] OP_REGION = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_OOM        = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_RESERVED   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL       = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_TABLE_FULL = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [ADDR_W-1:0] page_address;
      logic [ADDR_W-1:0] region_base;
      logic [LEN_W-1:0]  region_length;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   allocated_address;
      logic [STATUS_W-1:0] status;
      logic [FREE_W-1:0]   free_pages;
      logic [USED_W-1:0]   used_pages;
   } rsp_type;

   // region table write command
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] base;
      logic [LEN_W-1:0]  length;
   } region_cmd_type;

   // region table status toward the sequencer
   typedef struct packed {
      logic hit;
      logic full;
   } region_stat_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

FILE: design/pfsa_ram.sv
module pfsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/pfsa_region_table.sv
module pfsa_region_table #(
   parameter int MAX_REGIONS = pfsa_pkg::MAX_REGIONS_DEF,
   parameter int PAGE_BYTES  = pfsa_pkg::PAGE_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pfsa_pkg::region_cmd_type    cmd,
   input  logic [pfsa_pkg::ADDR_W-1:0] page,
   output pfsa_pkg::region_stat_type   stat
);

   localparam int RC_W  = $clog2(MAX_REGIONS + 1);
   localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

   logic [pfsa_pkg::ADDR_W-1:0] base_ff [MAX_REGIONS];
   logic [pfsa_pkg::END_W-1:0]  end_ff  [MAX_REGIONS];
   logic [RC_W-1:0]             count_ff;
   logic [RC_W-1:0]             count_in;
   logic [IDX_W-1:0]            wr_idx;
   logic [pfsa_pkg::LEN_W-1:0]  page_top;
   logic                        hit;

   assign wr_idx = count_ff[IDX_W-1:0];

   // region count
   always_comb begin
      count_in = count_ff;
      if (cmd.wr_en) begin
         count_in = count_ff + RC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // region store, inclusive end kept precomputed
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         base_ff[wr_idx] <= cmd.base;
         end_ff[wr_idx]  <= pfsa_pkg::END_W'(cmd.base) + pfsa_pkg::END_W'(cmd.length);
      end
   end

   // parallel overlap test against every live region
   assign page_top = pfsa_pkg::LEN_W'(page) + pfsa_pkg::LEN_W'(PAGE_BYTES);

   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < MAX_REGIONS; i++) begin
         if ((RC_W'(i) < count_ff)
             && (page_top > pfsa_pkg::LEN_W'(base_ff[i]))
             && (pfsa_pkg::END_W'(page) <= end_ff[i])) begin
            hit = 1'b1;
         end
      end
   end

   assign stat.hit  = hit;
   assign stat.full = (count_ff == RC_W'(MAX_REGIONS));

endmodule

FILE: design/page_frame_stack_allocator_unit.sv
// channel   ports                                   direction
// request   req_valid, req_stall, req_data          in (stall out)
// response  rsp_valid, rsp_stall, rsp_data          out (stall in)
//
// each operation has a transfer cycle that issues the stack
// read, then an execute state that uses the registered stack read data
// and writes back; the registered read port of the stack memory sets this split.
// reset clears the counts, the region count and both handshakes; no
// memory clearing pass. a stalled response holds in the output register;
// the next request is taken meanwhile and waits in execute until it frees.
module page_frame_stack_allocator_unit #(
   parameter int STACK_DEPTH = pfsa_pkg::STACK_DEPTH_DEF,
   parameter int MAX_REGIONS = pfsa_pkg::MAX_REGIONS_DEF,
   parameter int PAGE_BYTES  = pfsa_pkg::PAGE_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pfsa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pfsa_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int SA_W  = $clog2(STACK_DEPTH);

   pfsa_pkg::state_type state_ff, state_in;
   pfsa_pkg::req_type   req_ff, req_in;
   pfsa_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [pfsa_pkg::USED_W-1:0] used_ff, used_in;

   logic                        accept;
   logic                        finish;
   logic                        stk_wr_en;
   logic [SA_W-1:0]             stk_rd_addr;
   logic [pfsa_pkg::ADDR_W-1:0] stk_rd_data;
   logic [CNT_W-1:0]            count_dec;

   pfsa_pkg::region_cmd_type  reg_cmd;
   pfsa_pkg::region_stat_type reg_stat;

   assign req_stall = (state_ff != pfsa_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign finish    = (state_ff == pfsa_pkg::ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   // read the top of stack during the transfer cycle
   assign count_dec   = count_ff - CNT_W'(1);
   assign stk_rd_addr = count_dec[SA_W-1:0];

   pfsa_ram #(
      .WIDTH (pfsa_pkg::ADDR_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (count_ff[SA_W-1:0]),
      .wr_data (req_ff.page_address),
      .rd_en   (accept),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   pfsa_region_table #(
      .MAX_REGIONS (MAX_REGIONS),
      .PAGE_BYTES  (PAGE_BYTES)
   ) u_regions (
      .clock (clock),
      .reset (reset),
      .cmd   (reg_cmd),
      .page  (req_ff.page_address),
      .stat  (reg_stat)
   );

   // sequencer: next state, operation and response
   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      count_in       = count_ff;
      used_in        = used_ff;
      stk_wr_en      = 1'b0;
      reg_cmd.wr_en  = 1'b0;
      reg_cmd.base   = req_ff.region_base;
      reg_cmd.length = req_ff.region_length;

      case (state_ff)
         pfsa_pkg::ST_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               state_in = pfsa_pkg::ST_EXEC;
            end
         end
         pfsa_pkg::ST_EXEC: begin
            if (finish) begin
               rsp_in.allocated_address = '0;
               rsp_in.status            = pfsa_pkg::STAT_OK;
               case (req_ff.opcode)
                  pfsa_pkg::OP_ALLOC: begin
                     if (count_ff == '0) begin
                        rsp_in.status = pfsa_pkg::STAT_OOM;
                     end else begin
                        count_in                 = count_dec;
                        rsp_in.allocated_address = stk_rd_data;
                        if (used_ff != '1) begin
                           used_in = used_ff + pfsa_pkg::USED_W'(1);
                        end
                     end
                  end
                  pfsa_pkg::OP_FREE: begin
                     if (reg_stat.hit) begin
                        rsp_in.status = pfsa_pkg::STAT_RESERVED;
                     end else if (count_ff == CNT_W'(STACK_DEPTH)) begin
                        rsp_in.status = pfsa_pkg::STAT_FULL;
                     end else begin
                        stk_wr_en = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                        if (used_ff != '0) begin
                           used_in = used_ff - pfsa_pkg::USED_W'(1);
                        end
                     end
                  end
                  pfsa_pkg::OP_REGION: begin
                     if (reg_stat.full) begin
                        rsp_in.status = pfsa_pkg::STAT_TABLE_FULL;
                     end else begin
                        reg_cmd.wr_en = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_in.free_pages = pfsa_pkg::FREE_W'(count_in);
               rsp_in.used_pages = used_in;
               rsp_valid_in      = 1'b1;
               state_in          = pfsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pfsa_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfsa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         used_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
